[design/c8x_pkg.sv]
`timescale 1ns / 1ps
package c8x_pkg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
        logic [7:0]  disp_index;
        logic [7:0]  random_byte;
    } req_t;

    typedef struct packed {
        logic [11:0] pc_after;
        logic        collision;
        logic [7:0]  display_byte;
        logic        unsupported;
    } res_t;

    localparam logic [1:0] REQ_EXEC  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [3:0] OP_SYS = 4'h0;
    localparam logic [3:0] OP_JP  = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE  = 4'h3;
    localparam logic [3:0] OP_SNE = 4'h4;
    localparam logic [3:0] OP_LD  = 4'h6;
    localparam logic [3:0] OP_ADD = 4'h7;
    localparam logic [3:0] OP_ALU = 4'h8;
    localparam logic [3:0] OP_LDI = 4'hA;
    localparam logic [3:0] OP_RND = 4'hC;
    localparam logic [3:0] OP_DRW = 4'hD;
    localparam logic [3:0] OP_SKP = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SUBN = 4'h7;

    localparam logic [7:0] SYS_CLS = 8'hE0;
    localparam logic [7:0] SYS_RET = 8'hEE;
    localparam logic [7:0] SKP_KEY = 8'hA1;

    localparam logic [7:0] FX_GET_DT = 8'h07;
    localparam logic [7:0] FX_WAIT   = 8'h0A;
    localparam logic [7:0] FX_SET_DT = 8'h15;
    localparam logic [7:0] FX_SET_ST = 8'h18;
    localparam logic [7:0] FX_ADD_I  = 8'h1E;
    localparam logic [7:0] FX_FONT   = 8'h29;
    localparam logic [7:0] FX_BCD    = 8'h33;
    localparam logic [7:0] FX_LOAD   = 8'h65;

    localparam logic [11:0] PC_RESET = 12'h200;
    localparam logic [11:0] SP_TOP   = 12'hFFE;
    localparam logic [3:0]  FLAG_REG = 4'hF;

    localparam int FONT_BYTES = 80;
    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

[design/c8x_ram.sv]
`timescale 1ns / 1ps
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/chip8_instruction_execute.sv]
`timescale 1ns / 1ps
// CHIP-8 instruction core.
// Request channel: drive request and raise start; the beat is taken on a rising
// edge with start high and busy low. req_type picks execute, timer tick, memory
// byte write or display byte read.
// Result channel: every request yields one result beat, shown on result for one
// cycle with done high. The receiver cannot stall, so sample it then.
// Execution: an instruction first fetches its two bytes, then does two
// register-file reads; Fx33 writes its three digits in turn, Fx65 loads
// V0..Vx in turn, CLS clears the display byte by byte, and Dxyn works sprite
// row by sprite row, since every row is a read-modify-write of the display memory.
// The main, display and register memories are RAMs with a single read port,
// so each of them gives one read per cycle.
// One request is worked at a time; the next beat may enter on the cycle the
// result beat is shown.
// Reset: after rst_n rises, an init sweep clears the display, zeroes V0..VF
// and loads the font at 0..79; busy is high meanwhile.
module chip8_instruction_execute
    import c8x_pkg::*;
#(
    parameter int DISPLAY_ROWS = 32,
    parameter int ROW_BYTES = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output res_t result
);

    localparam int PLANE = DISPLAY_ROWS * ROW_BYTES;
    localparam int COLS = ROW_BYTES * 8;
    localparam int PAW = $clog2(PLANE);
    localparam int RW = $clog2(DISPLAY_ROWS);
    localparam int CW = $clog2(COLS);
    localparam int BW = CW - 3;
    localparam int INIT_LEN = (PLANE > FONT_BYTES) ? PLANE : FONT_BYTES;
    localparam int CNTW = $clog2(INIT_LEN + 1);

    typedef enum logic [21:0] {
        S_INIT  = 22'd1 << 0,
        S_IDLE  = 22'd1 << 1,
        S_F0    = 22'd1 << 2,
        S_F1    = 22'd1 << 3,
        S_R0    = 22'd1 << 4,
        S_R1    = 22'd1 << 5,
        S_EXEC  = 22'd1 << 6,
        S_WRX   = 22'd1 << 7,
        S_CALL1 = 22'd1 << 8,
        S_RET0  = 22'd1 << 9,
        S_RET1  = 22'd1 << 10,
        S_BCD1  = 22'd1 << 11,
        S_BCD2  = 22'd1 << 12,
        S_LDW   = 22'd1 << 13,
        S_CLR   = 22'd1 << 14,
        S_DB0   = 22'd1 << 15,
        S_DW0   = 22'd1 << 16,
        S_DW1   = 22'd1 << 17,
        S_DFIN  = 22'd1 << 18,
        S_DREAD = 22'd1 << 19,
        S_SPARE0 = 22'd1 << 20,
        S_SPARE1 = 22'd1 << 21
    } state_t;

    // Wrap a byte into [0, m) by repeated subtraction; m is at least 32.
    function automatic logic [7:0] wrap_mod(input logic [7:0] v, input logic [7:0] m);
        logic [7:0] r;
        r = v;
        for (int k = 0; k < 8; k++)
        begin
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [7:0]  b0_reg, b0_next, b1_reg, b1_next;
    logic [7:0]  vx_reg, vx_next, vy_reg, vy_next;
    logic [7:0]  wb_reg, wb_next, bits_reg, bits_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic hit_reg, hit_next;
    logic [11:0] pc_reg, pc_next, i_reg, i_next, sp_reg, sp_next;
    logic [7:0]  delay_reg, delay_next, sound_reg, sound_next;
    logic done_reg;
    res_t result_reg;

    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;
    logic           plane_we;
    logic [PAW-1:0] plane_waddr, plane_raddr;
    logic [7:0]     plane_wdata, plane_rdata;
    logic        reg_we;
    logic [3:0]  reg_waddr, reg_raddr;
    logic [7:0]  reg_wdata, reg_rdata;

    logic       fin, fin_coll, fin_unsup;
    logic [7:0] fin_byte;

    logic [3:0]  op, x, y, n;
    logic [11:0] nnn, pc2, pc4, sp_push, ret_addr;
    logic [8:0]  sum9;
    logic [1:0]  hund;
    logic [7:0]  rem, tens, ones;
    logic [14:0] tens_prod;
    logic [3:0]  dcnt;
    logic [2:0]  shift;
    logic [BW-1:0] byte0, byte1;
    logic [PAW-1:0] paddr0, paddr1;
    logic [7:0]  mask0, mask1;

    c8x_ram #(.WIDTH(8), .DEPTH(4096)) u_main (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    c8x_ram #(.WIDTH(8), .DEPTH(PLANE)) u_plane (
        .clk(clk), .we(plane_we), .waddr(plane_waddr), .wdata(plane_wdata),
        .raddr(plane_raddr), .rdata(plane_rdata)
    );

    c8x_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
        .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
        .raddr(reg_raddr), .rdata(reg_rdata)
    );

    // Instruction fields and shared address arithmetic.
    assign op  = b0_reg[7:4];
    assign x   = b0_reg[3:0];
    assign y   = b1_reg[7:4];
    assign n   = b1_reg[3:0];
    assign nnn = {b0_reg[3:0], b1_reg};
    assign pc2 = pc_reg + 12'd2;
    assign pc4 = pc_reg + 12'd4;
    assign sp_push  = (sp_reg == 12'd0) ? SP_TOP : (sp_reg - 12'd2);
    assign ret_addr = {wb_reg[3:0], mem_rdata} + 12'd2;
    assign sum9 = {1'b0, vx_reg} + {1'b0, vy_reg};

    // BCD: hundreds by compare, tens by reciprocal multiply (exact below 100).
    assign hund = (vx_reg >= 8'd200) ? 2'd2 : ((vx_reg >= 8'd100) ? 2'd1 : 2'd0);
    assign rem  = vx_reg - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
    assign tens_prod = 15'(rem) * 15'd205;
    assign tens = 8'(tens_prod[14:11]);
    assign ones = rem - 8'(tens * 8'd10);

    // Sprite row placement: a byte spans at most two display bytes.
    assign dcnt   = cnt_reg[3:0] + 4'd1;
    assign shift  = col_reg[2:0];
    assign byte0  = col_reg[CW-1:3];
    assign byte1  = (byte0 == BW'(ROW_BYTES - 1)) ? '0 : (byte0 + BW'(1));
    assign paddr0 = PAW'(row_reg) * PAW'(ROW_BYTES) + PAW'(byte0);
    assign paddr1 = PAW'(row_reg) * PAW'(ROW_BYTES) + PAW'(byte1);
    assign mask0  = bits_reg >> shift;
    assign mask1  = 8'(bits_reg << (4'd8 - {1'b0, shift}));

    always_comb
    begin
        state_next = state_reg;
        b0_next = b0_reg;
        b1_next = b1_reg;
        vx_next = vx_reg;
        vy_next = vy_reg;
        wb_next = wb_reg;
        bits_next = bits_reg;
        cnt_next = cnt_reg;
        row_next = row_reg;
        col_next = col_reg;
        hit_next = hit_reg;
        pc_next = pc_reg;
        i_next = i_reg;
        sp_next = sp_reg;
        delay_next = delay_reg;
        sound_next = sound_reg;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        plane_we = 1'b0;
        plane_waddr = '0;
        plane_wdata = '0;
        plane_raddr = '0;
        reg_we = 1'b0;
        reg_waddr = '0;
        reg_wdata = '0;
        reg_raddr = '0;
        fin = 1'b0;
        fin_coll = 1'b0;
        fin_unsup = 1'b0;
        fin_byte = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // Load the font, zero the registers and clear the display,
                // one entry per cycle.
                if (cnt_reg < CNTW'(FONT_BYTES))
                begin
                    mem_we = 1'b1;
                    mem_waddr = 12'(cnt_reg);
                    mem_wdata = FONT[cnt_reg[6:0]];
                end
                if (cnt_reg < CNTW'(16))
                begin
                    reg_we = 1'b1;
                    reg_waddr = cnt_reg[3:0];
                end
                if (cnt_reg < CNTW'(PLANE))
                begin
                    plane_we = 1'b1;
                    plane_waddr = PAW'(cnt_reg);
                end
                if (cnt_reg == CNTW'(INIT_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (request.req_type)
                        REQ_EXEC:
                        begin
                            mem_raddr = pc_reg;
                            state_next = S_F0;
                        end
                        REQ_TICK:
                        begin
                            if (delay_reg != 8'd0)
                            begin
                                delay_next = delay_reg - 8'd1;
                            end
                            if (sound_reg != 8'd0)
                            begin
                                sound_next = sound_reg - 8'd1;
                            end
                            fin = 1'b1;
                        end
                        REQ_WRITE:
                        begin
                            mem_we = 1'b1;
                            mem_waddr = request.mem_addr;
                            mem_wdata = request.mem_data;
                            fin = 1'b1;
                        end
                        REQ_READ:
                        begin
                            plane_raddr = PAW'(request.disp_index);
                            state_next = S_DREAD;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_DREAD:
            begin
                if (32'(req_reg.disp_index) < 32'(PLANE))
                begin
                    fin_byte = plane_rdata;
                end
                fin = 1'b1;
                state_next = S_IDLE;
            end
            S_F0:
            begin
                b0_next = mem_rdata;
                mem_raddr = pc_reg + 12'd1;
                state_next = S_F1;
            end
            S_F1:
            begin
                b1_next = mem_rdata;
                reg_raddr = b0_reg[3:0];
                state_next = S_R0;
            end
            S_R0:
            begin
                vx_next = reg_rdata;
                reg_raddr = b1_reg[7:4];
                state_next = S_R1;
            end
            S_R1:
            begin
                vy_next = reg_rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (op)
                    OP_SYS:
                    begin
                        if (y != 4'hE)
                        begin
                            pc_next = pc2;
                            fin = 1'b1;
                        end
                        else if (b0_reg == 8'h00 && b1_reg == SYS_CLS)
                        begin
                            cnt_next = '0;
                            state_next = S_CLR;
                        end
                        else if (b0_reg == 8'h00 && b1_reg == SYS_RET)
                        begin
                            mem_raddr = sp_reg;
                            state_next = S_RET0;
                        end
                        else
                        begin
                            fin = 1'b1;
                            fin_unsup = 1'b1;
                        end
                    end
                    OP_JP:
                    begin
                        pc_next = nnn;
                        fin = 1'b1;
                    end
                    OP_CALL:
                    begin
                        sp_next = sp_push;
                        mem_we = 1'b1;
                        mem_waddr = sp_push;
                        mem_wdata = {4'd0, pc_reg[11:8]};
                        state_next = S_CALL1;
                    end
                    OP_SE:
                    begin
                        pc_next = (vx_reg == b1_reg) ? pc4 : pc2;
                        fin = 1'b1;
                    end
                    OP_SNE:
                    begin
                        pc_next = (vx_reg != b1_reg) ? pc4 : pc2;
                        fin = 1'b1;
                    end
                    OP_LD:
                    begin
                        reg_we = 1'b1;
                        reg_waddr = x;
                        reg_wdata = b1_reg;
                        pc_next = pc2;
                        fin = 1'b1;
                    end
                    OP_ADD:
                    begin
                        reg_we = 1'b1;
                        reg_waddr = x;
                        reg_wdata = vx_reg + b1_reg;
                        pc_next = pc2;
                        fin = 1'b1;
                    end
                    OP_ALU:
                    begin
                        unique case (n)
                            ALU_MOV, ALU_AND, ALU_XOR:
                            begin
                                reg_we = 1'b1;
                                reg_waddr = x;
                                reg_wdata = (n == ALU_MOV) ? vy_reg :
                                            ((n == ALU_AND) ? (vx_reg & vy_reg)
                                                            : (vx_reg ^ vy_reg));
                                pc_next = pc2;
                                fin = 1'b1;
                            end
                            ALU_ADD:
                            begin
                                // Flag first, result second: Vx = VF keeps the sum.
                                reg_we = 1'b1;
                                reg_waddr = FLAG_REG;
                                reg_wdata = {7'd0, sum9[8]};
                                wb_next = sum9[7:0];
                                state_next = S_WRX;
                            end
                            ALU_SUB:
                            begin
                                reg_we = 1'b1;
                                reg_waddr = FLAG_REG;
                                reg_wdata = {7'd0, vx_reg > vy_reg};
                                wb_next = vx_reg - vy_reg;
                                state_next = S_WRX;
                            end
                            ALU_SUBN:
                            begin
                                reg_we = 1'b1;
                                reg_waddr = FLAG_REG;
                                reg_wdata = {7'd0, vy_reg > vx_reg};
                                wb_next = vy_reg - vx_reg;
                                state_next = S_WRX;
                            end
                            default:
                            begin
                                fin = 1'b1;
                                fin_unsup = 1'b1;
                            end
                        endcase
                    end
                    OP_LDI:
                    begin
                        i_next = nnn;
                        pc_next = pc2;
                        fin = 1'b1;
                    end
                    OP_RND:
                    begin
                        reg_we = 1'b1;
                        reg_waddr = x;
                        reg_wdata = b1_reg & req_reg.random_byte;
                        pc_next = pc2;
                        fin = 1'b1;
                    end
                    OP_DRW:
                    begin
                        if (n == 4'd0)
                        begin
                            reg_we = 1'b1;
                            reg_waddr = FLAG_REG;
                            pc_next = pc2;
                            fin = 1'b1;
                        end
                        else
                        begin
                            hit_next = 1'b0;
                            cnt_next = '0;
                            row_next = RW'(wrap_mod(vy_reg, 8'(DISPLAY_ROWS)));
                            col_next = CW'(wrap_mod(vx_reg, 8'(COLS)));
                            mem_raddr = i_reg;
                            state_next = S_DB0;
                        end
                    end
                    OP_SKP:
                    begin
                        if (b1_reg == SKP_KEY)
                        begin
                            pc_next = pc4;
                        end
                        else
                        begin
                            fin_unsup = 1'b1;
                        end
                        fin = 1'b1;
                    end
                    OP_MISC:
                    begin
                        pc_next = pc2;
                        fin = 1'b1;
                        unique case (b1_reg)
                            FX_GET_DT:
                            begin
                                reg_we = 1'b1;
                                reg_waddr = x;
                                reg_wdata = delay_reg;
                            end
                            FX_WAIT:
                            begin
                                pc_next = pc2;
                            end
                            FX_SET_DT:
                            begin
                                delay_next = vx_reg;
                            end
                            FX_SET_ST:
                            begin
                                sound_next = vx_reg;
                            end
                            FX_ADD_I:
                            begin
                                i_next = i_reg + 12'(vx_reg);
                            end
                            FX_FONT:
                            begin
                                if (vx_reg < 8'd16)
                                begin
                                    i_next = 12'({vx_reg[3:0], 2'b00}) + 12'(vx_reg[3:0]);
                                end
                            end
                            FX_BCD:
                            begin
                                pc_next = pc_reg;
                                fin = 1'b0;
                                mem_we = 1'b1;
                                mem_waddr = i_reg;
                                mem_wdata = {6'd0, hund};
                                wb_next = tens;
                                bits_next = ones;
                                state_next = S_BCD1;
                            end
                            FX_LOAD:
                            begin
                                pc_next = pc_reg;
                                fin = 1'b0;
                                cnt_next = '0;
                                mem_raddr = i_reg;
                                state_next = S_LDW;
                            end
                            default:
                            begin
                                pc_next = pc_reg;
                                fin_unsup = 1'b1;
                            end
                        endcase
                    end
                    default:
                    begin
                        fin = 1'b1;
                        fin_unsup = 1'b1;
                    end
                endcase
            end
            S_WRX:
            begin
                reg_we = 1'b1;
                reg_waddr = x;
                reg_wdata = wb_reg;
                pc_next = pc2;
                fin = 1'b1;
                state_next = S_IDLE;
            end
            S_CALL1:
            begin
                mem_we = 1'b1;
                mem_waddr = sp_reg + 12'd1;
                mem_wdata = pc_reg[7:0];
                pc_next = nnn;
                fin = 1'b1;
                state_next = S_IDLE;
            end
            S_RET0:
            begin
                wb_next = mem_rdata;
                mem_raddr = sp_reg + 12'd1;
                state_next = S_RET1;
            end
            S_RET1:
            begin
                pc_next = ret_addr;
                sp_next = (sp_reg == SP_TOP) ? 12'd0 : (sp_reg + 12'd2);
                fin = 1'b1;
                state_next = S_IDLE;
            end
            S_BCD1:
            begin
                mem_we = 1'b1;
                mem_waddr = i_reg + 12'd1;
                mem_wdata = wb_reg;
                state_next = S_BCD2;
            end
            S_BCD2:
            begin
                mem_we = 1'b1;
                mem_waddr = i_reg + 12'd2;
                mem_wdata = bits_reg;
                pc_next = pc2;
                fin = 1'b1;
                state_next = S_IDLE;
            end
            S_LDW:
            begin
                reg_we = 1'b1;
                reg_waddr = cnt_reg[3:0];
                reg_wdata = mem_rdata;
                if (cnt_reg[3:0] == x)
                begin
                    pc_next = pc2;
                    fin = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = CNTW'(dcnt);
                    mem_raddr = i_reg + 12'(dcnt);
                end
            end
            S_CLR:
            begin
                plane_we = 1'b1;
                plane_waddr = PAW'(cnt_reg);
                if (cnt_reg == CNTW'(PLANE - 1))
                begin
                    pc_next = pc2;
                    fin = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            S_DB0:
            begin
                bits_next = mem_rdata;
                plane_raddr = paddr0;
                state_next = S_DW0;
            end
            S_DW0, S_DW1:
            begin
                plane_we = 1'b1;
                if (state_reg == S_DW0)
                begin
                    plane_waddr = paddr0;
                    plane_wdata = plane_rdata ^ mask0;
                    hit_next = hit_reg | (|(plane_rdata & mask0));
                end
                else
                begin
                    plane_waddr = paddr1;
                    plane_wdata = plane_rdata ^ mask1;
                    hit_next = hit_reg | (|(plane_rdata & mask1));
                end
                if (state_reg == S_DW0 && shift != 3'd0)
                begin
                    plane_raddr = paddr1;
                    state_next = S_DW1;
                end
                else if (dcnt == n)
                begin
                    state_next = S_DFIN;
                end
                else
                begin
                    // Advance to the next sprite row with vertical wrap.
                    cnt_next = CNTW'(dcnt);
                    row_next = (row_reg == RW'(DISPLAY_ROWS - 1)) ? '0 : (row_reg + RW'(1));
                    mem_raddr = i_reg + 12'(dcnt);
                    state_next = S_DB0;
                end
            end
            S_DFIN:
            begin
                reg_we = 1'b1;
                reg_waddr = FLAG_REG;
                reg_wdata = {7'd0, hit_reg};
                pc_next = pc2;
                fin = 1'b1;
                fin_coll = hit_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg <= '0;
            pc_reg <= PC_RESET;
            i_reg <= '0;
            sp_reg <= '0;
            delay_reg <= '0;
            sound_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pc_reg <= pc_next;
            i_reg <= i_next;
            sp_reg <= sp_next;
            delay_reg <= delay_next;
            sound_reg <= sound_next;
            done_reg <= fin;
        end
    end

    // Payload registers: hold the request beat, the working instruction fields and operands, and the last result beat.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        b0_reg <= b0_next;
        b1_reg <= b1_next;
        vx_reg <= vx_next;
        vy_reg <= vy_next;
        wb_reg <= wb_next;
        bits_reg <= bits_next;
        row_reg <= row_next;
        col_reg <= col_next;
        hit_reg <= hit_next;
        if (fin)
        begin
            result_reg.pc_after <= pc_next;
            result_reg.collision <= fin_coll;
            result_reg.display_byte <= fin_byte;
            result_reg.unsupported <= fin_unsup;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither worked nor answered");

    a_flag_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.collision && result.unsupported))
        else $error("collision and unsupported both set");

    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_IDLE) |-> (start && request.req_type == REQ_WRITE))
        else $error("memory written while idle without a write request");
`endif

endmodule

[tb/tb_chip8_instruction_execute.sv]
`timescale 1ns / 1ps
module tb_chip8_instruction_execute;
    import c8x_pkg::*;

    localparam int ROWS       = 32;
    localparam int ROW_BYTES  = 8;
    localparam int PLANE      = ROWS * ROW_BYTES;
    localparam int COLS       = ROW_BYTES * 8;
    localparam int RAND_BEATS = 1800;
    localparam int IDLE_LIMIT = 4000;
    localparam int REQ_BITS   = $bits(req_t);

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t request;
    res_t result;

    chip8_instruction_execute #(
        .DISPLAY_ROWS(ROWS),
        .ROW_BYTES(ROW_BYTES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Shadow copy of the core's architectural state.
    logic [7:0]  cpu_mem [4096];
    bit          mem_written [4096];
    logic [7:0]  disp_plane [PLANE];
    logic [7:0]  vreg [16];
    logic [11:0] ireg;
    logic [11:0] pcreg;
    logic [11:0] spreg;
    logic [7:0]  delay_cnt;
    logic [7:0]  sound_cnt;

    res_t expected_results [$];
    int   mismatches;
    int   beats_sent;
    int   results_seen;
    int   exec_seen;
    int   collisions_seen;
    int   unsupported_seen;
    bit   no_idle;

    // Directed table: an instruction row stores its opcode at the current PC, then
    // executes it; a plain row is one raw beat.
    typedef struct {
        bit          is_instr;
        logic [1:0]  kind;
        logic [15:0] word;
        logic [7:0]  data;
        logic [7:0]  rnd;
        bit          typed;
        res_t        exp;
    } row_t;

    row_t directed_rows [$];

    localparam res_t IDLE_RESULT = '{pc_after: PC_RESET, collision: 1'b0,
                                     display_byte: 8'h00, unsupported: 1'b0};

    localparam logic [3:0] ALU_OPS [6] = '{ALU_MOV, ALU_AND, ALU_XOR, ALU_ADD,
                                           ALU_SUB, ALU_SUBN};
    localparam logic [7:0] MISC_OPS [8] = '{FX_GET_DT, FX_WAIT, FX_SET_DT, FX_SET_ST,
                                            FX_ADD_I, FX_FONT, FX_BCD, FX_LOAD};

    task automatic reset_shadow();
        for (int a = 0; a < 4096; a++)
        begin
            cpu_mem[a] = (a < FONT_BYTES) ? FONT[a] : 8'h00;
            mem_written[a] = (a < FONT_BYTES);
        end
        for (int a = 0; a < PLANE; a++)
            disp_plane[a] = 8'h00;
        for (int a = 0; a < 16; a++)
            vreg[a] = 8'h00;
        ireg = '0;
        pcreg = PC_RESET;
        spreg = '0;
        delay_cnt = '0;
        sound_cnt = '0;
    endtask

    // XOR one sprite into the plane with wrap on both axes; return 1 on erase.
    function automatic bit draw_sprite(logic [7:0] x0, logic [7:0] y0, logic [3:0] n);
        bit          hit;
        logic [7:0]  bits;
        logic [7:0]  mask;
        int          row;
        int          col;
        int          idx;
        logic [11:0] addr;
        hit = 1'b0;
        for (int r = 0; r < n; r++)
        begin
            addr = ireg + 12'(r);
            bits = cpu_mem[addr];
            row = (int'(y0) + r) % ROWS;
            for (int j = 0; j < 8; j++)
            begin
                if (bits[7 - j])
                begin
                    col = (int'(x0) + j) % COLS;
                    idx = row * ROW_BYTES + col / 8;
                    mask = 8'h80 >> (col % 8);
                    if ((disp_plane[idx] & mask) != 0)
                        hit = 1'b1;
                    disp_plane[idx] ^= mask;
                end
            end
        end
        return hit;
    endfunction

    // Execute the instruction at PC; returns the unsupported flag.
    function automatic bit run_instruction(logic [7:0] rnd, output bit hit);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [11:0] nnn;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [11:0] next;
        logic [11:0] ret;
        logic [8:0]  sum;
        hit = 1'b0;
        b0 = cpu_mem[pcreg];
        b1 = cpu_mem[pcreg + 12'd1];
        x = b0[3:0];
        y = b1[7:4];
        n = b1[3:0];
        nnn = {b0[3:0], b1};
        vx = vreg[x];
        vy = vreg[y];
        next = pcreg + 12'd2;
        case (b0[7:4])
            OP_SYS:
            begin
                if (y == 4'hE)
                begin
                    if (b0 == 8'h00 && b1 == SYS_CLS)
                    begin
                        for (int a = 0; a < PLANE; a++)
                            disp_plane[a] = 8'h00;
                    end
                    else if (b0 == 8'h00 && b1 == SYS_RET)
                    begin
                        ret = {cpu_mem[spreg][3:0], cpu_mem[spreg + 12'd1]};
                        spreg = (spreg == SP_TOP) ? 12'h000 : spreg + 12'd2;
                        next = ret + 12'd2;
                    end
                    else
                        return 1'b1;
                end
            end
            OP_JP:   next = nnn;
            OP_CALL:
            begin
                spreg = (spreg == 12'h000) ? SP_TOP : spreg - 12'd2;
                cpu_mem[spreg] = {4'h0, pcreg[11:8]};
                cpu_mem[spreg + 12'd1] = pcreg[7:0];
                mem_written[spreg] = 1'b1;
                mem_written[spreg + 12'd1] = 1'b1;
                next = nnn;
            end
            OP_SE:   if (vx == b1) next = pcreg + 12'd4;
            OP_SNE:  if (vx != b1) next = pcreg + 12'd4;
            OP_LD:   vreg[x] = b1;
            OP_ADD:  vreg[x] = vx + b1;
            OP_ALU:
            begin
                case (n)
                    ALU_MOV: vreg[x] = vy;
                    ALU_AND: vreg[x] = vx & vy;
                    ALU_XOR: vreg[x] = vx ^ vy;
                    ALU_ADD:
                    begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        vreg[FLAG_REG] = {7'd0, sum[8]};
                        vreg[x] = sum[7:0];
                    end
                    ALU_SUB:
                    begin
                        vreg[FLAG_REG] = {7'd0, vx > vy};
                        vreg[x] = vx - vy;
                    end
                    ALU_SUBN:
                    begin
                        vreg[FLAG_REG] = {7'd0, vy > vx};
                        vreg[x] = vy - vx;
                    end
                    default: return 1'b1;
                endcase
            end
            OP_LDI:  ireg = nnn;
            OP_RND:  vreg[x] = b1 & rnd;
            OP_DRW:
            begin
                // flag clears first, so a draw with VF as operand uses the old value
                vreg[FLAG_REG] = 8'h00;
                if (draw_sprite(vx, vy, n))
                begin
                    vreg[FLAG_REG] = 8'h01;
                    hit = 1'b1;
                end
            end
            OP_SKP:
            begin
                if (b1 == SKP_KEY)
                    next = pcreg + 12'd4;
                else
                    return 1'b1;
            end
            OP_MISC:
            begin
                case (b1)
                    FX_GET_DT: vreg[x] = delay_cnt;
                    FX_WAIT:   ;
                    FX_SET_DT: delay_cnt = vx;
                    FX_SET_ST: sound_cnt = vx;
                    FX_ADD_I:  ireg = ireg + 12'(vx);
                    FX_FONT:   if (vx < 8'd16) ireg = 12'(vx) * 12'd5;
                    FX_BCD:
                    begin
                        cpu_mem[ireg] = vx / 100;
                        cpu_mem[ireg + 12'd1] = (vx / 10) % 10;
                        cpu_mem[ireg + 12'd2] = vx % 10;
                        mem_written[ireg] = 1'b1;
                        mem_written[ireg + 12'd1] = 1'b1;
                        mem_written[ireg + 12'd2] = 1'b1;
                    end
                    FX_LOAD:
                        for (int k = 0; k <= x; k++)
                            vreg[k] = cpu_mem[ireg + 12'(k)];
                    default: return 1'b1;
                endcase
            end
            default: return 1'b1;
        endcase
        pcreg = next;
        return 1'b0;
    endfunction

    function automatic res_t predict_step(req_t r);
        res_t p;
        bit   hit;
        p = '0;
        hit = 1'b0;
        case (r.req_type)
            REQ_EXEC:
                p.unsupported = run_instruction(r.random_byte, hit);
            REQ_TICK:
            begin
                if (delay_cnt != 0) delay_cnt--;
                if (sound_cnt != 0) sound_cnt--;
            end
            REQ_WRITE:
            begin
                cpu_mem[r.mem_addr] = r.mem_data;
                mem_written[r.mem_addr] = 1'b1;
            end
            default:
                if (int'(r.disp_index) < PLANE) p.display_byte = disp_plane[r.disp_index];
        endcase
        p.collision = hit;
        p.pc_after = pcreg;
        return p;
    endfunction

    // Mostly back-to-back beats, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Fill every field with noise, then set the ones the request uses.
    function automatic req_t make_req(logic [1:0] kind, logic [11:0] addr, logic [7:0] data,
                                      logic [7:0] disp, logic [7:0] rnd);
        req_t r;
        r = REQ_BITS'({$urandom, $urandom});
        r.req_type = kind;
        if (kind == REQ_WRITE)
        begin
            r.mem_addr = addr;
            r.mem_data = data;
        end
        if (kind == REQ_READ) r.disp_index = disp;
        if (kind == REQ_EXEC) r.random_byte = rnd;
        return r;
    endfunction

    task automatic send_beat(req_t r, bit typed, res_t exp);
        int   g;
        res_t p;
        g = pick_gap();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        p = predict_step(r);
        expected_results.push_back(typed ? exp : p);
        beats_sent++;
    endtask

    // Write random bytes into any of count bytes from addr on that were never written.
    task automatic fill_unwritten(logic [11:0] addr, int count);
        logic [11:0] a;
        for (int k = 0; k < count; k++)
        begin
            a = addr + 12'(k);
            if (!mem_written[a])
                send_beat(make_req(REQ_WRITE, a, 8'($urandom), 8'h00, 8'h00), 1'b0, '0);
        end
    endtask

    // Make sure every byte that the instruction at PC reads has been written.
    task automatic prepare_exec();
        logic [7:0] b0;
        logic [7:0] b1;
        fill_unwritten(pcreg, 2);
        b0 = cpu_mem[pcreg];
        b1 = cpu_mem[pcreg + 12'd1];
        if (b0 == 8'h00 && b1 == SYS_RET)
            fill_unwritten(spreg, 2);
        else if (b0[7:4] == OP_DRW)
            fill_unwritten(ireg, int'(b1[3:0]));
        else if (b0[7:4] == OP_MISC && b1 == FX_LOAD)
            fill_unwritten(ireg, int'(b0[3:0]) + 1);
    endtask

    // Store an opcode at the current PC, then execute it.
    task automatic send_instruction(logic [15:0] op, logic [7:0] rnd);
        send_beat(make_req(REQ_WRITE, pcreg, op[15:8], 8'h00, 8'h00), 1'b0, '0);
        send_beat(make_req(REQ_WRITE, pcreg + 12'd1, op[7:0], 8'h00, 8'h00), 1'b0, '0);
        prepare_exec();
        send_beat(make_req(REQ_EXEC, 12'h000, 8'h00, 8'h00, rnd), 1'b0, '0);
    endtask

    function automatic row_t instr_row(logic [15:0] op, logic [7:0] rnd);
        row_t t;
        t = '{is_instr: 1'b1, kind: REQ_EXEC, word: op, data: 8'h00, rnd: rnd,
              typed: 1'b0, exp: '0};
        return t;
    endfunction

    function automatic row_t raw_row(logic [1:0] kind, logic [11:0] a, logic [7:0] d,
                                     bit typed, res_t exp);
        row_t t;
        t = '{is_instr: 1'b0, kind: kind, word: {4'h0, a}, data: d, rnd: 8'h00,
              typed: typed, exp: exp};
        return t;
    endfunction

    function automatic logic [15:0] random_opcode();
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  kk;
        logic [11:0] nnn;
        logic [3:0]  spare [3];
        x = $urandom_range(0, 15);
        y = $urandom_range(0, 15);
        kk = $urandom_range(0, 255);
        nnn = $urandom_range(0, 4095);
        spare = '{4'h5, 4'h9, 4'hB};
        case ($urandom_range(0, 31))
            0:       return {8'h00, SYS_CLS};
            1, 2:    return {8'h00, SYS_RET};
            3:       return {OP_SYS, nnn};
            4:       return {OP_JP, nnn};
            5, 6:    return {OP_CALL, nnn};
            7:       return {OP_SE, x, ($urandom_range(0, 1) ? vreg[x] : kk)};
            8:       return {OP_SNE, x, ($urandom_range(0, 1) ? vreg[x] : kk)};
            9, 10:   return {OP_LD, x, kk};
            11:      return {OP_ADD, x, kk};
            12, 13, 14, 15:
                return {OP_ALU, x, y, ALU_OPS[$urandom_range(0, 5)]};
            16:      return {OP_LDI, nnn};
            17:      return {OP_RND, x, kk};
            18, 19, 20:
                return {OP_DRW, x, y, 4'($urandom_range(0, 15))};
            21:      return {OP_SKP, x, SKP_KEY};
            22, 23, 24, 25, 26, 27, 28:
                return {OP_MISC, x, MISC_OPS[$urandom_range(0, 7)]};
            29:      return {spare[$urandom_range(0, 2)], nnn};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    endtask

    // Check every result beat against the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("[%0t] result beat with nothing expected", $realtime);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.pc_after !== want.pc_after)
                    report_mismatch("pc_after", result.pc_after, want.pc_after);
                if (result.collision !== want.collision)
                    report_mismatch("collision", result.collision, want.collision);
                if (result.display_byte !== want.display_byte)
                    report_mismatch("display_byte", result.display_byte, want.display_byte);
                if (result.unsupported !== want.unsupported)
                    report_mismatch("unsupported", result.unsupported, want.unsupported);
                if (want.collision) collisions_seen++;
                if (want.unsupported) unsupported_seen++;
            end
        end
    end

    // Watchdog: count cycles with neither an accepted beat nor a result beat.
    int idle_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d cycles without progress", IDLE_LIMIT);
            $display("FAIL chip8_instruction_execute");
            $finish;
        end
    end

    initial
    begin
        int rand_sent;
        int pick;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        mismatches = 0;
        beats_sent = 0;
        results_seen = 0;
        exec_seen = 0;
        collisions_seen = 0;
        unsupported_seen = 0;
        no_idle = 1'b0;
        reset_shadow();

        // Directed part: reset state, flag corner cases, every opcode family.
        directed_rows.push_back(raw_row(REQ_READ, 12'h000, 8'h00, 1'b1, IDLE_RESULT));
        directed_rows.push_back(raw_row(REQ_READ, 12'h0FF, 8'h00, 1'b1, IDLE_RESULT));
        directed_rows.push_back(raw_row(REQ_TICK, 12'h000, 8'h00, 1'b1, IDLE_RESULT));
        directed_rows.push_back(raw_row(REQ_WRITE, 12'hFFF, 8'hFF, 1'b1, IDLE_RESULT));
        directed_rows.push_back(instr_row(16'h6005, 8'h00));
        directed_rows.push_back(instr_row(16'hF029, 8'h00));
        directed_rows.push_back(instr_row(16'hD015, 8'h00));
        directed_rows.push_back(instr_row(16'hD015, 8'h00));
        directed_rows.push_back(instr_row(16'h60FF, 8'h00));
        directed_rows.push_back(instr_row(16'h8004, 8'h00));
        directed_rows.push_back(instr_row(16'h6F80, 8'h00));
        directed_rows.push_back(instr_row(16'h8FF4, 8'h00));
        directed_rows.push_back(instr_row(16'h8105, 8'h00));
        directed_rows.push_back(instr_row(16'h8017, 8'h00));
        directed_rows.push_back(instr_row(16'h8013, 8'h00));
        directed_rows.push_back(instr_row(16'hC0F0, 8'hA5));
        directed_rows.push_back(instr_row(16'hF015, 8'h00));
        directed_rows.push_back(instr_row(16'hF018, 8'h00));
        directed_rows.push_back(raw_row(REQ_TICK, 12'h000, 8'h00, 1'b0, '0));
        directed_rows.push_back(instr_row(16'hF107, 8'h00));
        directed_rows.push_back(instr_row(16'hF033, 8'h00));
        directed_rows.push_back(instr_row(16'hF265, 8'h00));
        directed_rows.push_back(instr_row(16'h2300, 8'h00));
        directed_rows.push_back(instr_row(16'h00EE, 8'h00));
        directed_rows.push_back(instr_row(16'h00E0, 8'h00));
        directed_rows.push_back(instr_row(16'h3000, 8'h00));
        directed_rows.push_back(instr_row(16'h4000, 8'h00));
        directed_rows.push_back(instr_row(16'hE0A1, 8'h00));
        directed_rows.push_back(instr_row(16'hF00A, 8'h00));
        directed_rows.push_back(instr_row(16'h0123, 8'h00));
        directed_rows.push_back(instr_row(16'h00E5, 8'h00));
        directed_rows.push_back(instr_row(16'h800E, 8'h00));
        directed_rows.push_back(instr_row(16'hF0FF, 8'h00));
        directed_rows.push_back(instr_row(16'h61F0, 8'h00));
        directed_rows.push_back(instr_row(16'hF129, 8'h00));
        directed_rows.push_back(instr_row(16'hAFFF, 8'h00));
        directed_rows.push_back(instr_row(16'hF165, 8'h00));
        directed_rows.push_back(instr_row(16'hF01E, 8'h00));
        directed_rows.push_back(instr_row(16'h1FFE, 8'h00));
        directed_rows.push_back(instr_row(16'h7001, 8'h00));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].is_instr)
            begin
                send_instruction(directed_rows[k].word, directed_rows[k].rnd);
                exec_seen++;
            end
            else
                send_beat(make_req(directed_rows[k].kind, directed_rows[k].word[11:0],
                                   directed_rows[k].data, directed_rows[k].word[7:0], 8'h00),
                          directed_rows[k].typed, directed_rows[k].exp);
        end

        // Random part: mostly store-then-execute sequences, with ticks, display
        // reads, stray writes and re-execution of whatever sits at PC. Bytes an
        // execute reads are written first when they never were.
        rand_sent = 0;
        while (beats_sent < RAND_BEATS)
        begin
            if ((rand_sent % 50) == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            rand_sent++;
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_instruction(random_opcode(), 8'($urandom));
                exec_seen++;
            end
            else
            begin
                if (pick < 78)
                begin
                    prepare_exec();
                    send_beat(make_req(REQ_EXEC, 12'h000, 8'h00, 8'h00, 8'($urandom)), 1'b0, '0);
                end
                else if (pick < 87)
                    send_beat(make_req(REQ_TICK, 12'h000, 8'h00, 8'h00, 8'h00), 1'b0, '0);
                else if (pick < 95)
                    send_beat(make_req(REQ_READ, 12'h000, 8'h00, 8'($urandom), 8'h00), 1'b0, '0);
                else
                    send_beat(make_req(REQ_WRITE, 12'($urandom), 8'($urandom), 8'h00, 8'h00),
                              1'b0, '0);
                if (pick < 78) exec_seen++;
            end
        end
        start <= 1'b0;

        // Drain: hold until every expected beat has come back, then let any
        // stray beat show up.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("%0d request beats sent, %0d result beats checked, %0d executes",
                 beats_sent, results_seen, exec_seen);
        $display("%0d draws with collision, %0d unsupported opcodes, %0d mismatches",
                 collisions_seen, unsupported_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS chip8_instruction_execute");
        else
            $display("FAIL chip8_instruction_execute");
        $finish;
    end

endmodule

[chip8_instruction_execute.f]
design/c8x_pkg.sv
design/c8x_ram.sv
design/chip8_instruction_execute.sv
tb/tb_chip8_instruction_execute.sv
